// File: rtl/i2cm_pkg.sv
// Shared types and constants of the I2C master bit engine.
package i2cm_pkg;

	// Command codes carried by an input item.
	typedef enum logic [2:0] {
		CMD_NONE   = 3'd0,
		CMD_START  = 3'd1,
		CMD_STOP   = 3'd2,
		CMD_WRITE  = 3'd3,
		CMD_READ   = 3'd4,
		CMD_CHKACK = 3'd5,
		CMD_ACK    = 3'd6,
		CMD_NACK   = 3'd7
	} cmd_t;

	// Completion status codes.
	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_BUS_BUSY = 2'd1,
		STAT_BUS_ERR  = 2'd2,
		STAT_NO_ACK   = 2'd3
	} stat_t;

	// Reset value of the phase length register.
	localparam logic [15:0] PHASE_TICKS_RST = 16'd255;

	// Number of bits moved by one byte command.
	localparam logic [3:0] BYTE_BITS = 4'd8;

	// Sequencer state.
	typedef struct packed {
		logic [15:0] tick;
		logic [1:0]  phase;
		logic [3:0]  bits;
		logic [7:0]  shift;
		cmd_t        cmd;
		logic        scl;
		logic        sda;
		logic [7:0]  rx;
		stat_t       status;
	} st_t;

	// One input item.
	typedef struct packed {
		logic [2:0] cmd;
		logic [7:0] tx;
		logic       sda;
	} item_t;

	// One result item.
	typedef struct packed {
		logic       scl_release;
		logic       sda_release;
		logic       busy;
		logic       done;
		logic [7:0] rx_byte;
		logic [1:0] status;
	} res_t;

endpackage

// File: rtl/i2cm_step.sv
// Next-state and result logic of the bit engine for one tick.
module i2cm_step (
	input  i2cm_pkg::st_t   cur,
	input  i2cm_pkg::item_t item,
	input  logic [15:0]     phase_ticks,
	output i2cm_pkg::st_t   nxt,
	output i2cm_pkg::res_t  res
);
	import i2cm_pkg::*;

	// Step indices within a command.
	localparam logic [1:0] PH_FIRST  = 2'd0;
	localparam logic [1:0] PH_SECOND = 2'd1;
	localparam logic [1:0] PH_THIRD  = 2'd2;
	localparam logic [1:0] PH_FOURTH = 2'd3;

	typedef struct packed {
		logic fin;
		st_t  st;
	} fin_t;

	st_t         n_st;
	fin_t        f;
	logic        done;
	logic [15:0] limit;
	logic [15:0] tick_inc;

	// Line changes made when a step begins.
	function automatic st_t enter_step(st_t s);
		st_t r;
		r = s;
		unique case (s.cmd)
			CMD_START: begin
				if (s.phase == PH_FIRST) begin
					r.scl = 1'b1;
					r.sda = 1'b1;
				end else if (s.phase == PH_SECOND) begin
					r.sda = 1'b0;
				end else begin
					r.scl = 1'b0;
				end
			end
			CMD_STOP: begin
				case (s.phase)
					PH_FIRST:  r.scl = 1'b0;
					PH_SECOND: r.sda = 1'b0;
					PH_THIRD:  r.scl = 1'b1;
					default:   r.sda = 1'b1;
				endcase
			end
			CMD_CHKACK: begin
				case (s.phase)
					PH_FIRST:  r.scl = 1'b0;
					PH_SECOND: r.sda = 1'b1;
					default:   r.scl = 1'b1;
				endcase
			end
			CMD_ACK, CMD_NACK: begin
				case (s.phase)
					PH_FIRST:  r.scl = 1'b0;
					PH_SECOND: r.sda = (s.cmd == CMD_NACK);
					PH_THIRD:  r.scl = 1'b1;
					default:   r.scl = 1'b0;
				endcase
			end
			CMD_WRITE: begin
				if (s.phase == PH_FIRST) begin
					r.scl = 1'b0;
				end else if (s.phase == PH_SECOND) begin
					r.sda   = s.shift[7];
					r.shift = {s.shift[6:0], 1'b0};
				end else begin
					r.scl = 1'b1;
				end
			end
			CMD_READ: begin
				if (s.phase == PH_FIRST) begin
					if (s.bits == 4'd0) begin
						r.sda = 1'b1;
					end
					r.shift = {s.shift[6:0], 1'b0};
					r.scl   = 1'b0;
				end else begin
					r.scl = 1'b1;
				end
			end
			default: begin
				r = s;
			end
		endcase
		return r;
	endfunction

	// End of a step: sample SDA and decide whether the command finishes.
	function automatic fin_t finish_step(st_t s, logic sda);
		fin_t r;
		r.fin = 1'b0;
		r.st  = s;
		unique case (s.cmd)
			CMD_START: begin
				if (s.phase == PH_FIRST && !sda) begin
					r.st.status = STAT_BUS_BUSY;
					r.fin       = 1'b1;
				end else if (s.phase == PH_SECOND && sda) begin
					r.st.status = STAT_BUS_ERR;
					r.fin       = 1'b1;
				end else if (s.phase >= PH_THIRD) begin
					r.fin = 1'b1;
				end else begin
					r.st.phase = s.phase + 2'd1;
				end
			end
			CMD_STOP, CMD_ACK, CMD_NACK: begin
				if (s.phase == PH_FOURTH) begin
					r.fin = 1'b1;
				end else begin
					r.st.phase = s.phase + 2'd1;
				end
			end
			CMD_CHKACK: begin
				if (s.phase >= PH_THIRD) begin
					r.st.status = sda ? STAT_NO_ACK : STAT_OK;
					r.st.scl    = 1'b0;
					r.fin       = 1'b1;
				end else begin
					r.st.phase = s.phase + 2'd1;
				end
			end
			CMD_WRITE: begin
				if (s.phase >= PH_THIRD) begin
					r.st.bits = s.bits + 4'd1;
					if (r.st.bits >= BYTE_BITS) begin
						r.st.scl = 1'b0;
						r.fin    = 1'b1;
					end else begin
						r.st.phase = PH_FIRST;
					end
				end else begin
					r.st.phase = s.phase + 2'd1;
				end
			end
			CMD_READ: begin
				if (s.phase >= PH_SECOND) begin
					r.st.shift = {s.shift[7:1], sda};
					r.st.bits  = s.bits + 4'd1;
					if (r.st.bits >= BYTE_BITS) begin
						r.st.scl = 1'b0;
						r.st.rx  = r.st.shift;
						r.fin    = 1'b1;
					end else begin
						r.st.phase = PH_FIRST;
					end
				end else begin
					r.st.phase = s.phase + 2'd1;
				end
			end
			default: begin
				r.fin = 1'b1;
			end
		endcase
		return r;
	endfunction

	// Start a command when idle, otherwise count the hold and advance the step.
	always_comb begin
		n_st     = cur;
		done     = 1'b0;
		f        = '{fin: 1'b0, st: cur};
		tick_inc = cur.tick + 16'd1;
		limit    = (phase_ticks == 16'd0) ? 16'd1 : phase_ticks;
		if (cur.cmd == CMD_NONE) begin
			if (cmd_t'(item.cmd) != CMD_NONE) begin
				n_st.cmd    = cmd_t'(item.cmd);
				n_st.phase  = PH_FIRST;
				n_st.bits   = 4'd0;
				n_st.tick   = 16'd0;
				n_st.status = STAT_OK;
				n_st.shift  = (cmd_t'(item.cmd) == CMD_WRITE) ? item.tx : 8'd0;
				n_st        = enter_step(n_st);
			end
		end else begin
			n_st.tick = tick_inc;
			if (tick_inc >= limit) begin
				n_st.tick = 16'd0;
				f         = finish_step(n_st, item.sda);
				n_st      = f.st;
				if (f.fin) begin
					n_st.cmd   = CMD_NONE;
					n_st.phase = PH_FIRST;
					n_st.bits  = 4'd0;
					done       = 1'b1;
				end else begin
					n_st = enter_step(n_st);
				end
			end
		end
	end

	// Result item seen after this tick.
	assign nxt             = n_st;
	assign res.scl_release = n_st.scl;
	assign res.sda_release = n_st.sda;
	assign res.busy        = (n_st.cmd != CMD_NONE);
	assign res.done        = done;
	assign res.rx_byte     = n_st.rx;
	assign res.status      = n_st.status;

endmodule

// File: rtl/i2cm_skid.sv
// Two-entry output register with a spare entry so the input side sees a registered stall.
module i2cm_skid (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  i2cm_pkg::res_t in_data,
	output logic           out_valid,
	input  logic           out_stall,
	output i2cm_pkg::res_t out_data
);
	import i2cm_pkg::*;

	logic out_valid_q;
	logic spare_valid_q;
	res_t out_data_q;
	res_t spare_data_q;
	logic push;
	logic load;

	assign push     = in_valid && !spare_valid_q;
	assign load     = !out_valid_q || !out_stall;
	assign in_stall = spare_valid_q;

	// Valid flags of the main and spare entries.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q   <= 1'b0;
			spare_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q   <= spare_valid_q || push;
			spare_valid_q <= 1'b0;
		end else if (push) begin
			spare_valid_q <= 1'b1;
		end
	end

	// Payload of the main and spare entries.
	always_ff @(posedge clk) begin
		if (load) begin
			out_data_q <= spare_valid_q ? spare_data_q : in_data;
		end else if (push) begin
			spare_data_q <= in_data;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

`ifndef SYNTH
	// The spare entry only fills behind a held main entry.
	a_spare_behind_main: assert property (@(posedge clk) disable iff (!arst_n)
		spare_valid_q |-> out_valid_q)
		else $error("spare entry valid while main entry empty");
	// A held item is not dropped when the spare entry fills.
	a_spare_only_when_held: assert property (@(posedge clk) disable iff (!arst_n)
		(!spare_valid_q && out_valid_q && out_stall && in_valid) |=> spare_valid_q)
		else $error("item lost while the main entry was held");
`endif

endmodule

// File: rtl/i2c_master_bit_engine_top.sv
// I2C master bit engine: open-drain SCL/SDA sequencer advanced one tick per item.
// Each accepted item is one tick of the bus sequencer and produces exactly one result
// item. Items are taken one per clock cycle while in_stall is low; a result is offered
// once its item moves from the input register into the output register. The output
// side holds two results, so the input keeps flowing while one result waits. The cmd
// field is taken only when no command is running. The user writes phase_ticks through
// cfg_wr_en/cfg_wr_data only while the engine is idle; the block does not enforce it.
module i2c_master_bit_engine_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  cmd,
	input  logic [7:0]  tx_byte,
	input  logic        sda_in,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        scl_release,
	output logic        sda_release,
	output logic        busy_res,
	output logic        done_res,
	output logic [7:0]  rx_byte,
	output logic [1:0]  status
);
	import i2cm_pkg::*;

	logic [15:0] phase_ticks_q;
	logic        valid_s1;
	item_t       item_s1;
	st_t         st_q;
	st_t         st_nxt;
	res_t        res;
	res_t        out_res;
	logic        skid_stall;
	logic        fire;

	assign in_stall = valid_s1 && skid_stall;
	assign fire     = valid_s1 && !skid_stall;

	// Phase length register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_ticks_q <= PHASE_TICKS_RST;
		end else if (cfg_wr_en) begin
			phase_ticks_q <= cfg_wr_data;
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= '{cmd: cmd, tx: tx_byte, sda: sda_in};
		end
	end

	// Sequencer state advances once per item handed to the output side.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '{tick: 16'd0, phase: 2'd0, bits: 4'd0, shift: 8'd0, cmd: CMD_NONE,
				scl: 1'b1, sda: 1'b1, rx: 8'd0, status: STAT_OK};
		end else if (fire) begin
			st_q <= st_nxt;
		end
	end

	i2cm_step u_step (
		.cur         (st_q),
		.item        (item_s1),
		.phase_ticks (phase_ticks_q),
		.nxt         (st_nxt),
		.res         (res)
	);

	i2cm_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s1),
		.in_stall  (skid_stall),
		.in_data   (res),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_res)
	);

	assign scl_release = out_res.scl_release;
	assign sda_release = out_res.sda_release;
	assign busy_res    = out_res.busy;
	assign done_res    = out_res.done;
	assign rx_byte     = out_res.rx_byte;
	assign status      = out_res.status;

`ifndef SYNTH
	// The hold counter stays below the phase length while a command runs.
	a_tick_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.cmd != CMD_NONE) |-> (st_q.tick < phase_ticks_q || phase_ticks_q == 16'd0))
		else $error("hold counter passed the phase length");
	// An idle engine has its step and bit counters cleared.
	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.cmd == CMD_NONE) |-> (st_q.phase == 2'd0 && st_q.bits == 4'd0))
		else $error("idle engine left with step or bit count");
	// A finishing tick leaves the engine idle.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && res.done) |=> (st_q.cmd == CMD_NONE))
		else $error("command still active after done");
`endif

endmodule
